// ===== hdl/key_remap_table_unit_defines.svh =====
// Assertion macros used by the key remap table engine.
`ifndef KEY_REMAP_TABLE_UNIT_DEFINES_SVH
`define KEY_REMAP_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checks an implication on every clock edge outside reset.
`define KRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Checks an implication with the consequent in the next cycle, on every clock edge outside reset.
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KRT_ASSERT_IMP(lbl, ante, cons, msg)
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/krt_pkg.sv =====
// Types and constants of the key remap table.
`default_nettype none

package krt_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KEY_W = 16;
  localparam int unsigned ENTRY_W = 2 * KEY_W;

  localparam logic [KEY_W-1:0] MISS_KEY = 16'hFFFF;
  localparam logic [KEY_W-1:0] ZERO_KEY = 16'h0000;

  // Request kinds.
  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_CHANGED = 2'd0;
  localparam logic [1:0] ST_UNCHANGED = 2'd1;
  localparam logic [1:0] ST_ZERO_SRC = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] source_key;
    logic [KEY_W-1:0] new_key;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [KEY_W-1:0] mapped_key;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/krt_req_if.sv =====
// Request channel interface of the key remap table.
`default_nettype none

interface krt_req_if import krt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] source_key;
  logic [KEY_W-1:0] new_key;

  modport source (output valid, output action, output source_key, output new_key,
                  input ready);
  modport sink (input valid, input action, input source_key, input new_key,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/krt_rsp_if.sv =====
// Result channel interface of the key remap table.
`default_nettype none

interface krt_rsp_if import krt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             found;
  logic [KEY_W-1:0] mapped_key;

  modport source (output valid, output status, output found, output mapped_key,
                  input ready);
  modport sink (input valid, input status, input found, input mapped_key,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/key_remap_table_unit.sv =====
// Top level of the key remap table: request intake, engine and result register.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------
//  req_i   | in  | valid / ready | action, source_key, new_key
//  rsp_o   | out | valid / ready | status, found, mapped_key
//
// One request at a time, through the states idle, scan, decide, move (removals
// only) and resp; scan reads one entry per cycle through the table memory's
// single read port, at most the entry count; a zero-source set goes straight to
// resp. Reset clears the entry count, sequencer state and output valid; the store
// content is undefined and never read past the count. A held result sits in the
// output register while the next request is taken; the engine waits when full.
`default_nettype none

module key_remap_table_unit import krt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);

  req_t eng_req;
  rsp_t eng_res;
  logic eng_ready;
  logic eng_res_valid;
  logic res_take;
  logic out_valid_q, out_valid_d;
  rsp_t out_q;

  assign eng_req = '{action: req_i.action, source_key: req_i.source_key,
                     new_key: req_i.new_key};

  krt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (eng_req),
    .req_ready_o (eng_ready),
    .res_valid_o (eng_res_valid),
    .res_o       (eng_res),
    .res_take_i  (res_take)
  );

  assign req_i.ready = eng_ready;

  // The output register takes a result when empty or being drained.
  assign res_take = eng_res_valid && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= eng_res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.found      = out_q.found;
  assign rsp_o.mapped_key = out_q.mapped_key;

endmodule

`default_nettype wire

// ===== hdl/krt_engine.sv =====
// Table memory, entry count and the scan sequencer of the key remap table.
`default_nettype none
`include "key_remap_table_unit_defines.svh"

module krt_engine import krt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  input  wire req_t req_i,
  output logic      req_ready_o,
  output logic      res_valid_o,
  output rsp_t      res_o,
  input  wire logic res_take_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic               hit_q, hit_d;
  logic [KEY_W-1:0]   old_q, old_d;
  req_t               req_q, req_d;
  rsp_t               res_q, res_d;

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic               match;
  logic [CNT_W-1:0]   idx_next;
  logic [CNT_W-1:0]   cnt_last;

  assign match    = (rd_data_q[ENTRY_W-1:KEY_W] == req_q.source_key);
  assign idx_next = {1'b0, idx_q} + CNT_W'(1);
  assign cnt_last = cnt_q - CNT_W'(1);

  // Table store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Sequencer: scan one entry per cycle, then update the table where a set changes it.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    slot_d  = slot_q;
    hit_d   = hit_q;
    old_d   = old_q;
    req_d   = req_q;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_data = {req_q.source_key, req_q.new_key};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          if (req_i.action == ACT_SET && req_i.source_key == ZERO_KEY) begin
            res_d   = '{status: ST_ZERO_SRC, found: 1'b0, mapped_key: MISS_KEY};
            state_d = S_RESP;
          end else if (cnt_q == '0) begin
            hit_d   = 1'b0;
            state_d = S_DECIDE;
          end else begin
            idx_d   = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_d   = 1'b1;
          slot_d  = idx_q;
          old_d   = rd_data_q[KEY_W-1:0];
          state_d = S_DECIDE;
        end else if (idx_next == cnt_q) begin
          hit_d   = 1'b0;
          state_d = S_DECIDE;
        end else begin
          idx_d   = idx_next[IDX_W-1:0];
          rd_en   = 1'b1;
          rd_addr = idx_next[IDX_W-1:0];
        end
      end
      S_DECIDE: begin
        state_d = S_RESP;
        if (hit_q) begin
          if (req_q.action == ACT_LOOKUP || old_q == req_q.new_key) begin
            res_d = '{status: ST_UNCHANGED, found: 1'b1, mapped_key: old_q};
          end else if (req_q.new_key == req_q.source_key) begin
            // Removal: fetch the last entry to move it into the freed slot.
            res_d   = '{status: ST_CHANGED, found: 1'b1, mapped_key: old_q};
            rd_en   = 1'b1;
            rd_addr = cnt_last[IDX_W-1:0];
            state_d = S_MOVE;
          end else begin
            wr_en = 1'b1;
            res_d = '{status: ST_CHANGED, found: 1'b1, mapped_key: old_q};
          end
        end else begin
          if (req_q.action == ACT_LOOKUP) begin
            res_d = '{status: ST_UNCHANGED, found: 1'b0, mapped_key: MISS_KEY};
          end else if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
            res_d = '{status: ST_FULL, found: 1'b0, mapped_key: MISS_KEY};
          end else begin
            // Append behind the last live entry.
            wr_en   = 1'b1;
            wr_addr = cnt_q[IDX_W-1:0];
            cnt_d   = cnt_q + CNT_W'(1);
            res_d   = '{status: ST_CHANGED, found: 1'b0, mapped_key: MISS_KEY};
          end
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_data_q;
        cnt_d   = cnt_last;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    slot_q <= slot_d;
    hit_q  <= hit_d;
    old_q  <= old_d;
    req_q  <= req_d;
    res_q  <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  `KRT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_ENTRIES),
                  "entry count exceeds table size")
  `KRT_ASSERT_NEXT(a_cnt_hold, state_q != S_DECIDE && state_q != S_MOVE, $stable(cnt_q),
                   "entry count changed outside an update step")
  `KRT_ASSERT_IMP(a_full_cnt, res_valid_o && res_q.status == ST_FULL,
                  cnt_q == CNT_W'(TABLE_ENTRIES), "full reported with room left")
  `KRT_ASSERT_IMP(a_scan_idx, state_q == S_SCAN, {1'b0, idx_q} < cnt_q,
                  "scan index beyond live entries")

endmodule

`default_nettype wire

// ===== tb/tb_key_remap_table_unit.sv =====
// Self-checking testbench of the key remap table: random and directed set and lookup requests.
`timescale 1ns / 1ps

module tb_key_remap_table_unit import krt_pkg::*; ();

  localparam int POOL_SIZE = 300;
  localparam int FILL_KEYS = 280;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  krt_req_if req_if ();
  krt_rsp_if rsp_if ();

  key_remap_table_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the remap table, updated at every accepted request.
  logic [KEY_W-1:0] shadow_src [TABLE_ENTRIES];
  logic [KEY_W-1:0] shadow_dst [TABLE_ENTRIES];
  int               shadow_count;

  req_t             remap_requests [$];
  rsp_t             predicted_results [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [KEY_W-1:0] dst_pool [8];

  int     accepted_reqs;
  int     total_reqs = 1;
  int     mismatch_count;
  int     quiet_cycles;
  int     idle_stage;
  int     send_idle_pct;
  int     recv_idle_pct;
  logic   req_took;
  req_t   next_req;
  req_t   taken_req;
  rsp_t   got_rsp;
  rsp_t   want_rsp;

  always #4 clk_i = ~clk_i;

  // Works out the result of one request and applies it to the shadow table.
  function automatic rsp_t remap_predict(input req_t r);
    rsp_t res;
    int   slot;
    res.status = ST_UNCHANGED;
    res.found = 1'b0;
    res.mapped_key = MISS_KEY;
    slot = -1;
    if (r.action == ACT_SET && r.source_key == ZERO_KEY) begin
      res.status = ST_ZERO_SRC;
      return res;
    end
    for (int i = 0; i < shadow_count; i++) begin
      if (slot < 0 && shadow_src[i] == r.source_key) slot = i;
    end
    if (slot >= 0) begin
      res.found = 1'b1;
      res.mapped_key = shadow_dst[slot];
      if (r.action == ACT_LOOKUP || shadow_dst[slot] == r.new_key) begin
        res.status = ST_UNCHANGED;
      end else if (r.new_key == r.source_key) begin
        // Removal: the last entry takes over the freed slot.
        shadow_src[slot] = shadow_src[shadow_count-1];
        shadow_dst[slot] = shadow_dst[shadow_count-1];
        shadow_count--;
        res.status = ST_CHANGED;
      end else begin
        shadow_dst[slot] = r.new_key;
        res.status = ST_CHANGED;
      end
    end else if (r.action == ACT_SET) begin
      if (shadow_count >= TABLE_ENTRIES) begin
        res.status = ST_FULL;
      end else begin
        shadow_src[shadow_count] = r.source_key;
        shadow_dst[shadow_count] = r.new_key;
        shadow_count++;
        res.status = ST_CHANGED;
      end
    end
    return res;
  endfunction

  task automatic queue_req(input logic act, input logic [KEY_W-1:0] src,
                           input logic [KEY_W-1:0] dst);
    req_t r;
    r.action = act;
    r.source_key = src;
    r.new_key = dst;
    remap_requests.push_back(r);
  endtask

  // Mixed traffic over a narrow key range so that hits, replacements and removals recur.
  task automatic queue_churn(input int n);
    logic [KEY_W-1:0] src;
    logic [KEY_W-1:0] dst;
    logic             act;
    int               pick;
    for (int k = 0; k < n; k++) begin
      act = ($urandom_range(0, 99) < 30) ? ACT_LOOKUP : ACT_SET;
      pick = $urandom_range(0, 99);
      if (pick < 80) src = key_pool[$urandom_range(0, 39)];
      else if (pick < 90) src = 16'($urandom);
      else if (pick < 95) src = ZERO_KEY;
      else src = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 30) dst = src;
      else if (pick < 90) dst = dst_pool[$urandom_range(0, 7)];
      else dst = 16'($urandom);
      queue_req(act, src, dst);
    end
  endtask

  // Stimulus build, reset and end of run.
  initial begin
    logic [KEY_W-1:0] cand;
    logic             dup;
    int               order [FILL_KEYS];
    int               j;
    int               tmp;
    int               pick;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_SET;
    req_if.source_key = ZERO_KEY;
    req_if.new_key = ZERO_KEY;
    rsp_if.ready = 1'b0;

    // Distinct nonzero source keys, so that a fill pass overruns the table.
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        cand = 16'($urandom);
        dup = (cand == ZERO_KEY);
        for (int m = 0; m < i; m++) begin
          if (key_pool[m] == cand) dup = 1'b1;
        end
      end while (dup);
      key_pool[i] = cand;
    end
    dst_pool[0] = ZERO_KEY;
    dst_pool[1] = MISS_KEY;
    for (int i = 2; i < 8; i++) dst_pool[i] = 16'($urandom);

    // Directed: empty table, zero sources, identity entries, removals of any slot.
    queue_req(ACT_LOOKUP, ZERO_KEY, ZERO_KEY);
    queue_req(ACT_LOOKUP, 16'hFFFF, 16'hFFFF);
    queue_req(ACT_SET, ZERO_KEY, ZERO_KEY);
    queue_req(ACT_SET, ZERO_KEY, 16'hFFFF);
    queue_req(ACT_SET, 16'hFFFF, 16'h0000);
    queue_req(ACT_SET, 16'h0001, 16'hFFFF);
    queue_req(ACT_SET, 16'hFFFF, 16'h0000);
    queue_req(ACT_SET, 16'hFFFF, 16'h1234);
    queue_req(ACT_LOOKUP, 16'hFFFF, 16'h0000);
    queue_req(ACT_SET, 16'h8000, 16'h8000);
    queue_req(ACT_SET, 16'h8000, 16'h8000);
    queue_req(ACT_LOOKUP, 16'h8000, 16'hFFFF);
    queue_req(ACT_SET, 16'h0001, 16'h0001);
    queue_req(ACT_LOOKUP, 16'h0001, 16'h0000);
    queue_req(ACT_LOOKUP, 16'h8000, 16'h0000);
    queue_req(ACT_SET, 16'h8000, 16'h7FFF);
    queue_req(ACT_SET, 16'h8000, 16'h8000);
    queue_req(ACT_LOOKUP, ZERO_KEY, 16'hFFFF);
    queue_req(ACT_SET, 16'hFFFF, 16'hFFFF);
    queue_req(ACT_LOOKUP, 16'hFFFF, 16'hFFFF);
    queue_req(ACT_SET, ZERO_KEY, 16'h5555);
    queue_req(ACT_SET, 16'hAAAA, 16'h5555);
    queue_req(ACT_LOOKUP, 16'hAAAA, 16'hAAAA);

    queue_churn(300);

    // Fill the table past its size, work on it while full, then drain it in random order.
    for (int i = 0; i < FILL_KEYS; i++) begin
      queue_req(ACT_SET, key_pool[i], dst_pool[$urandom_range(0, 7)]);
      order[i] = i;
    end
    for (int k = 0; k < 60; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        queue_req(ACT_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)], 16'($urandom));
      end else if (pick < 75) begin
        queue_req(ACT_SET, key_pool[$urandom_range(FILL_KEYS, POOL_SIZE - 1)],
                  16'($urandom));
      end else begin
        queue_req(ACT_SET, key_pool[$urandom_range(0, FILL_KEYS - 1)],
                  dst_pool[$urandom_range(0, 7)]);
      end
    end
    for (int i = FILL_KEYS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < FILL_KEYS; i++) begin
      queue_req(ACT_SET, key_pool[order[i]], key_pool[order[i]]);
      if ($urandom_range(0, 9) == 0) begin
        queue_req(ACT_LOOKUP, key_pool[$urandom_range(0, FILL_KEYS - 1)], ZERO_KEY);
      end
    end

    queue_churn(1550 - remap_requests.size());
    total_reqs = remap_requests.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (remap_requests.size() != 0 || req_if.valid || predicted_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: request and ready change at the falling edge, with idling by run stage.
  always @(negedge clk_i) begin
    idle_stage = (accepted_reqs * 3) / total_reqs;
    send_idle_pct = (idle_stage == 0) ? 8 : (idle_stage == 1) ? 88 : 0;
    recv_idle_pct = (idle_stage == 0) ? 88 : (idle_stage == 1) ? 8 : 0;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_took) begin
      if (remap_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = remap_requests.pop_front();
        req_if.valid <= 1'b1;
        req_if.action <= next_req.action;
        req_if.source_key <= next_req.source_key;
        req_if.new_key <= next_req.new_key;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predicts at each request transfer and checks each result transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_took <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        taken_req.action = req_if.action;
        taken_req.source_key = req_if.source_key;
        taken_req.new_key = req_if.new_key;
        predicted_results.push_back(remap_predict(taken_req));
        accepted_reqs++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got_rsp.status = rsp_if.status;
        got_rsp.found = rsp_if.found;
        got_rsp.mapped_key = rsp_if.mapped_key;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none pending: status %0d found %0d mapped_key %h",
                   $time, got_rsp.status, got_rsp.found, got_rsp.mapped_key);
        end else begin
          want_rsp = predicted_results.pop_front();
          if (got_rsp.status !== want_rsp.status || got_rsp.found !== want_rsp.found ||
              got_rsp.mapped_key !== want_rsp.mapped_key) begin
            mismatch_count++;
            $display("%0t: expected status %0d found %0d mapped_key %h, got %0d %0d %h",
                     $time, want_rsp.status, want_rsp.found, want_rsp.mapped_key,
                     got_rsp.status, got_rsp.found, got_rsp.mapped_key);
          end
        end
      end
      // Watchdog over cycles without any transfer.
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
